// File: src/rxs_pkg.sv
// Shared types and constants for the record exchange sorter.
// Used by the controller, the datapath, the top level and the checker.
package rxs_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int NAME_BYTES  = 8;

    localparam int ROLL_W      = 16;
    localparam int MARKS_W     = 14;
    localparam int NAME_PORT_W = 64;
    localparam int NAME_W      = 8 * NAME_BYTES;

    // Table index and fill count (the count must hold MAX_RECORDS itself).
    localparam int IDX_W = $clog2(MAX_RECORDS);
    localparam int CNT_W = $clog2(MAX_RECORDS + 1);

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_SORT_BY_NAME = 1'b0;   // register index, taken from paddr[2]

    typedef struct packed {
        logic [ROLL_W-1:0]  roll;
        logic [MARKS_W-1:0] marks;
        logic [NAME_W-1:0]  name;
    } record_t;

    localparam int REC_W = $bits(record_t);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ_I,
        ST_FETCH,
        ST_CMP,
        ST_WB,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    typedef enum logic {
        WSEL_INPUT,
        WSEL_HOLD
    } wsel_t;

    typedef struct packed {
        logic             we;
        wsel_t            wsel;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] raddr;
        logic             hold_load;
        logic             out_load;
        logic             out_last;
        logic             drop_set;
        logic             drop_clr;
    } dp_cmd_t;

    typedef struct packed {
        logic swap;
        logic out_free;
    } dp_status_t;

endpackage

// File: src/rxs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Self-contained; no package dependency.
module rxs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/rxs_ctrl.sv
// Sequencer for loading, exchange sorting and emitting the record table.
// Depends on rxs_pkg for the state type and the command/status structs.
module rxs_ctrl
    import rxs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_last_record,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] i_plus;
    logic             full;
    logic             accept;

    assign last_idx = IDX_W'(count_reg - CNT_W'(1));
    assign i_plus   = i_reg + IDX_W'(1);
    assign full     = (count_reg >= CNT_W'(MAX_RECORDS));
    assign accept   = (state_reg == ST_LOAD) && s_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid && s_last_record) begin
                    // With one record or fewer there is nothing to sort.
                    state_next = (count_reg != '0) ? ST_READ_I : ST_EMIT_RD;
                end
            end
            ST_READ_I: state_next = ST_FETCH;
            ST_FETCH:  state_next = ST_CMP;
            ST_CMP: begin
                if (j_reg == last_idx) begin
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                state_next = (i_plus == last_idx) ? ST_EMIT_RD : ST_READ_I;
            end
            ST_EMIT_RD: state_next = ST_EMIT_LD;
            ST_EMIT_LD: begin
                if (status.out_free) begin
                    state_next = (k_reg == last_idx) ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // Outputs and counters.
    always_comb begin
        cmd        = '0;
        cmd.wsel   = WSEL_INPUT;
        cmd.raddr  = i_reg;
        cmd.waddr  = i_reg;
        s_ready    = 1'b0;
        count_next = count_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (accept) begin
                    if (!full) begin
                        cmd.we     = 1'b1;
                        cmd.waddr  = IDX_W'(count_reg);
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        cmd.drop_set = 1'b1;
                    end
                    i_next = '0;
                    k_next = '0;
                end
            end
            ST_READ_I: begin
                cmd.raddr = i_reg;
            end
            ST_FETCH: begin
                cmd.hold_load = 1'b1;
                cmd.raddr     = i_plus;
                j_next        = i_plus;
            end
            ST_CMP: begin
                // The held entry moves to slot j and the smaller one is kept.
                if (status.swap) begin
                    cmd.we        = 1'b1;
                    cmd.wsel      = WSEL_HOLD;
                    cmd.waddr     = j_reg;
                    cmd.hold_load = 1'b1;
                end
                cmd.raddr = j_reg + IDX_W'(1);
                if (j_reg != last_idx) begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            ST_WB: begin
                cmd.we    = 1'b1;
                cmd.wsel  = WSEL_HOLD;
                cmd.waddr = i_reg;
                i_next    = i_plus;
                k_next    = '0;
            end
            ST_EMIT_RD: begin
                cmd.raddr = k_reg;
            end
            ST_EMIT_LD: begin
                cmd.raddr = k_reg;
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = (k_reg == last_idx);
                    if (k_reg == last_idx) begin
                        cmd.drop_clr = 1'b1;
                        count_next   = '0;
                    end else begin
                        k_next = k_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: src/rxs_datapath.sv
// Record table, compare unit, held entry, output register and config register.
// Depends on rxs_pkg and instantiates rxs_ram.
module rxs_datapath
    import rxs_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    input  logic [ROLL_W-1:0]      s_roll_number,
    input  logic [MARKS_W-1:0]     s_marks_hundredths,
    input  logic [NAME_PORT_W-1:0] s_name_bytes,
    output logic [ROLL_W-1:0]      m_out_roll_number,
    output logic [MARKS_W-1:0]     m_out_marks,
    output logic [NAME_PORT_W-1:0] m_out_name,
    output logic                   m_out_last,
    output logic                   m_overflow,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    record_t in_rec;
    record_t wdata;
    record_t rdata;
    record_t hold_reg;
    record_t out_reg;
    logic    out_last_reg;
    logic    out_ovf_reg;
    logic    m_valid_reg, m_valid_next;
    logic    drop_reg, drop_next;
    logic    sort_by_name_reg;
    logic    greater;

    assign in_rec.roll  = s_roll_number;
    assign in_rec.marks = s_marks_hundredths;
    assign in_rec.name  = NAME_W'(s_name_bytes);

    always_comb begin
        case (cmd.wsel)
            WSEL_HOLD: wdata = hold_reg;
            default:   wdata = in_rec;
        endcase
    end

    rxs_ram #(
        .WIDTH(REC_W),
        .DEPTH(MAX_RECORDS)
    ) u_table (
        .aclk (aclk),
        .we   (cmd.we),
        .waddr(cmd.waddr),
        .wdata(wdata),
        .raddr(cmd.raddr),
        .rdata(rdata)
    );

    // Names compare as unsigned numbers, which matches byte-wise string order.
    assign greater = sort_by_name_reg ? (hold_reg.name > rdata.name)
                                      : (hold_reg.marks > rdata.marks);

    assign status.swap     = greater;
    assign status.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.hold_load) begin
            hold_reg <= rdata;
        end
        if (cmd.out_load) begin
            out_reg      <= rdata;
            out_last_reg <= cmd.out_last;
            out_ovf_reg  <= drop_reg;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        drop_next = drop_reg;
        if (cmd.drop_clr) begin
            drop_next = 1'b0;
        end else if (cmd.drop_set) begin
            drop_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg      <= 1'b0;
            drop_reg         <= 1'b0;
            sort_by_name_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            drop_reg    <= drop_next;
            if (psel && penable && pwrite && (paddr[2] == REG_SORT_BY_NAME)) begin
                sort_by_name_reg <= pwdata[0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_SORT_BY_NAME) ? PDATA_W'(sort_by_name_reg) : '0;
    assign pready = 1'b1;

    assign m_out_roll_number = out_reg.roll;
    assign m_out_marks       = out_reg.marks;
    assign m_out_name        = NAME_PORT_W'(out_reg.name);
    assign m_out_last        = out_last_reg;
    assign m_overflow        = out_ovf_reg;
    assign m_valid           = m_valid_reg;

endmodule

// File: src/record_exchange_sorter_unit.sv
// Record exchange sorter: collects records, sorts them and streams them out.
// Uses rxs_pkg and instantiates rxs_ctrl and rxs_datapath.
//
// Records come in on the s_ channel, one transfer per cycle while s_ready is
// high. Up to MAX_RECORDS are kept; further records are dropped and every
// record of that set leaves with m_overflow set. The transfer with
// s_last_record high closes the set and starts the sort: s_ready drops until
// the last record of the set is loaded for the m_ channel. The key is the marks,
// or the name as an unsigned number when sort_by_name (APB register 0) is
// set; equal keys keep their order of the exchange sort.
// Sorting does one compare per cycle on the table's single read port, with
// read, fetch and write-back states around each pass. Each sorted record
// is then read from the table and loaded into the output register;
// m_out_last marks the final one. A stalled m_ready holds the
// output register and the sequencer waits. After the final transfer has
// been loaded the table is empty and s_ready is high again.
// Reset (aresetn low at a clock edge) empties the table, clears the overflow
// flag and the output valid, and sets sort_by_name to 0.
module record_exchange_sorter_unit
    import rxs_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [ROLL_W-1:0]      s_roll_number,
    input  logic [MARKS_W-1:0]     s_marks_hundredths,
    input  logic [NAME_PORT_W-1:0] s_name_bytes,
    input  logic                   s_last_record,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [ROLL_W-1:0]      m_out_roll_number,
    output logic [MARKS_W-1:0]     m_out_marks,
    output logic [NAME_PORT_W-1:0] m_out_name,
    output logic                   m_out_last,
    output logic                   m_overflow,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    dp_cmd_t    cmd;
    dp_status_t status;

    rxs_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_last_record(s_last_record),
        .s_ready      (s_ready),
        .status       (status),
        .cmd          (cmd)
    );

    rxs_datapath u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .s_roll_number     (s_roll_number),
        .s_marks_hundredths(s_marks_hundredths),
        .s_name_bytes      (s_name_bytes),
        .m_out_roll_number (m_out_roll_number),
        .m_out_marks       (m_out_marks),
        .m_out_name        (m_out_name),
        .m_out_last        (m_out_last),
        .m_overflow        (m_overflow),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

endmodule

// File: src/rxs_checker.sv
// Port-level checks for the record exchange sorter, bound to the top level.
// Uses rxs_pkg for port widths.
module rxs_checker
    import rxs_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   s_last_record,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [ROLL_W-1:0]      m_out_roll_number,
    input logic [MARKS_W-1:0]     m_out_marks,
    input logic [NAME_PORT_W-1:0] m_out_name,
    input logic                   m_out_last,
    input logic                   m_overflow,
    input logic                   pready
);

    // Reset empties the output register.
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_roll_number)
            && $stable(m_out_marks) && $stable(m_out_name)
            && $stable(m_out_last) && $stable(m_overflow))
        else $error("stalled result changed");

    // No new records are taken while a set is still being sent out.
    a_no_load_mid_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_out_last |-> !s_ready)
        else $error("input ready in the middle of an output set");

    // The last record of a set stops the input side for the sort.
    a_last_stops_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_record |=> !s_ready)
        else $error("input ready right after the last record");

    a_pready_high: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind record_exchange_sorter_unit rxs_checker u_rxs_checker (.*);

// File: dv/testbench.sv
// Self-checking testbench for record_exchange_sorter_unit: directed records,
// then random record sets, checked against a sorting predictor kept here (single-record results are typed in).
// Depends on rxs_pkg and the RTL under src/.
module testbench;
    import rxs_pkg::*;

    localparam int ITEM_TARGET   = 210;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DIR_ROWS      = 13;
    localparam logic [PADDR_W-1:0] SORT_BY_NAME_ADDR = PADDR_W'(4 * int'(REG_SORT_BY_NAME));

    typedef struct packed {
        logic [ROLL_W-1:0]      roll;
        logic [MARKS_W-1:0]     marks;
        logic [NAME_PORT_W-1:0] name;
        logic                   last;
    } item_t;

    typedef struct packed {
        logic [ROLL_W-1:0]      roll;
        logic [MARKS_W-1:0]     marks;
        logic [NAME_PORT_W-1:0] name;
        logic                   last;
        logic                   ovf;
    } result_t;

    typedef struct packed {
        logic    set_cfg;
        logic    cfg_val;
        item_t   item;
        logic    typed;
        result_t want;
    } stim_row_t;

    localparam result_t NO_RESULT = '{default: '0};

    logic                   aclk               = 1'b0;
    logic                   aresetn            = 1'b0;
    logic                   s_valid            = 1'b0;
    logic                   s_ready;
    logic [ROLL_W-1:0]      s_roll_number      = '0;
    logic [MARKS_W-1:0]     s_marks_hundredths = '0;
    logic [NAME_PORT_W-1:0] s_name_bytes       = '0;
    logic                   s_last_record      = 1'b0;
    logic                   m_valid;
    logic                   m_ready            = 1'b0;
    logic [ROLL_W-1:0]      m_out_roll_number;
    logic [MARKS_W-1:0]     m_out_marks;
    logic [NAME_PORT_W-1:0] m_out_name;
    logic                   m_out_last;
    logic                   m_overflow;
    logic                   psel               = 1'b0;
    logic                   penable            = 1'b0;
    logic                   pwrite             = 1'b0;
    logic [PADDR_W-1:0]     paddr              = '0;
    logic [PDATA_W-1:0]     pwdata             = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    // Predictor state: the record table, its fill count and the drop flag.
    record_t   roster [MAX_RECORDS];
    int        roster_fill      = 0;
    logic      roster_dropped   = 1'b0;
    logic      sort_by_name_cfg = 1'b0;
    result_t   sorted_q [$];
    stim_row_t dir_table [DIR_ROWS];

    int   err_count   = 0;
    int   items_sent  = 0;
    int   cycle_count = 0;
    int   stall_left  = 0;
    logic quiet       = 1'b0;

    record_exchange_sorter_unit u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_roll_number      (s_roll_number),
        .s_marks_hundredths (s_marks_hundredths),
        .s_name_bytes       (s_name_bytes),
        .s_last_record      (s_last_record),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_roll_number  (m_out_roll_number),
        .m_out_marks        (m_out_marks),
        .m_out_name         (m_out_name),
        .m_out_last         (m_out_last),
        .m_overflow         (m_overflow),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[record_exchange_sorter_unit] ERROR");
            $finish;
        end
    end

    // Stores one record and, on the closing record of a set, sorts the table
    // and queues every stored record in sorted order.
    function automatic void take_record(input item_t it);
        int      i;
        int      j;
        logic    greater;
        record_t held;
        result_t res;
        if (roster_fill < MAX_RECORDS) begin
            roster[roster_fill] = '{roll: it.roll, marks: it.marks, name: it.name[NAME_W-1:0]};
            roster_fill++;
        end else begin
            roster_dropped = 1'b1;
        end
        if (!it.last) return;
        for (i = 0; i < roster_fill; i++) begin
            for (j = i + 1; j < roster_fill; j++) begin
                greater = sort_by_name_cfg ? (roster[i].name > roster[j].name)
                                           : (roster[i].marks > roster[j].marks);
                if (greater) begin
                    held      = roster[i];
                    roster[i] = roster[j];
                    roster[j] = held;
                end
            end
        end
        for (i = 0; i < roster_fill; i++) begin
            res.roll  = roster[i].roll;
            res.marks = roster[i].marks;
            res.name  = NAME_PORT_W'(roster[i].name);
            res.last  = (i == roster_fill - 1);
            res.ovf   = roster_dropped;
            sorted_q.push_back(res);
        end
        roster_fill    = 0;
        roster_dropped = 1'b0;
    endfunction

    // dup_keys narrows the keys so that equal marks and equal names are common.
    function automatic item_t random_record(input logic dup_keys);
        item_t it;
        it.roll = ROLL_W'($urandom_range(0, 65535));
        if (dup_keys) begin
            it.marks = MARKS_W'($urandom_range(0, 4) * 2500);
            it.name  = {8'($urandom_range(8'h41, 8'h43)), 48'h0, 8'($urandom_range(0, 1))};
        end else begin
            if ($urandom_range(0, 7) == 0)
                it.marks = MARKS_W'($urandom_range(0, 16383));
            else
                it.marks = MARKS_W'($urandom_range(0, 10000));
            it.name = NAME_PORT_W'({$urandom, $urandom}) << (8 * $urandom_range(0, 7));
        end
        it.last = 1'b0;
        return it;
    endfunction

    task automatic send_record(input item_t it);
        s_valid            <= 1'b1;
        s_roll_number      <= it.roll;
        s_marks_hundredths <= it.marks;
        s_name_bytes       <= it.name;
        s_last_record      <= it.last;
        do @(posedge aclk); while (!(s_valid && s_ready));
        take_record(it);
        items_sent++;
    endtask

    task automatic sender_pause();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    // Waits until every queued result has left the block, then lets it settle.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sorted_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_sort_key(input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SORT_BY_NAME_ADDR;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sort_by_name_cfg = value[0];
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== PDATA_W'(sort_by_name_cfg)) begin
            $error("prdata: expected %0h, got %0h", PDATA_W'(sort_by_name_cfg), prdata);
            err_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Receiver side: random stall bursts, none once the run goes quiet.
    always @(posedge aclk) begin
        if (quiet) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= (stall_left == 1);
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 12);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (m_valid && m_ready) begin
            if (sorted_q.size() == 0) begin
                $error("unexpected transfer: roll %0h", m_out_roll_number);
                err_count++;
            end else begin
                want = sorted_q.pop_front();
                if (m_out_roll_number !== want.roll) begin
                    $error("out_roll_number: expected %0h, got %0h", want.roll, m_out_roll_number);
                    err_count++;
                end
                if (m_out_marks !== want.marks) begin
                    $error("out_marks: expected %0d, got %0d", want.marks, m_out_marks);
                    err_count++;
                end
                if (m_out_name !== want.name) begin
                    $error("out_name: expected %0h, got %0h", want.name, m_out_name);
                    err_count++;
                end
                if (m_out_last !== want.last) begin
                    $error("out_last: expected %0b, got %0b", want.last, m_out_last);
                    err_count++;
                end
                if (m_overflow !== want.ovf) begin
                    $error("overflow: expected %0b, got %0b", want.ovf, m_overflow);
                    err_count++;
                end
            end
        end
    end

    initial begin
        int                 r;
        int                 k;
        int                 set_no;
        int                 set_size;
        logic               dup_keys;
        item_t              it;
        logic [PDATA_W-1:0] cfg_word;

        // A single record comes back unchanged, so its result is typed in.
        dir_table = '{
            '{1'b0, 1'b0, '{16'hFFFF, 14'd10000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1}, 1'b1,
              '{16'hFFFF, 14'd10000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0}},
            '{1'b0, 1'b0, '{16'h0000, 14'd0, 64'h0, 1'b1}, 1'b1,
              '{16'h0000, 14'd0, 64'h0, 1'b1, 1'b0}},
            '{1'b0, 1'b0, '{16'd1, 14'd500, 64'h4200_0000_0000_0000, 1'b0}, 1'b0, NO_RESULT},
            '{1'b0, 1'b0, '{16'd2, 14'd16383, 64'h4100_0000_0000_0000, 1'b0}, 1'b0, NO_RESULT},
            '{1'b0, 1'b0, '{16'd3, 14'd0, 64'h4300_0000_0000_0000, 1'b0}, 1'b0, NO_RESULT},
            '{1'b0, 1'b0, '{16'd4, 14'd500, 64'h4400_0000_0000_0000, 1'b0}, 1'b0, NO_RESULT},
            '{1'b0, 1'b0, '{16'd5, 14'd9999, 64'h4500_0000_0000_0000, 1'b1}, 1'b0, NO_RESULT},
            '{1'b1, 1'b1, '{16'd10, 14'd10, 64'h4100_4200_0000_0000, 1'b0}, 1'b0, NO_RESULT},
            '{1'b0, 1'b0, '{16'd11, 14'd20, 64'h4100_0000_0000_0000, 1'b0}, 1'b0, NO_RESULT},
            '{1'b0, 1'b0, '{16'd12, 14'd30, 64'h0000_0000_0000_0041, 1'b0}, 1'b0, NO_RESULT},
            '{1'b0, 1'b0, '{16'd13, 14'd40, 64'h4100_0000_0000_0000, 1'b0}, 1'b0, NO_RESULT},
            '{1'b0, 1'b0, '{16'd14, 14'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1}, 1'b0, NO_RESULT},
            '{1'b0, 1'b0, '{16'h8000, 14'h2000, 64'h8000_0000_0000_0001, 1'b1}, 1'b1,
              '{16'h8000, 14'h2000, 64'h8000_0000_0000_0001, 1'b1, 1'b0}}
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The first sets run with the register still at its reset value.
        for (r = 0; r < DIR_ROWS; r++) begin
            if (dir_table[r].set_cfg) begin
                drain_results();
                write_sort_key(PDATA_W'(dir_table[r].cfg_val));
            end
            send_record(dir_table[r].item);
            if (dir_table[r].typed) begin
                void'(sorted_q.pop_back());
                sorted_q.push_back(dir_table[r].want);
            end
            sender_pause();
        end

        // Random sets: mostly small, one exactly full and one that overflows,
        // with the closing record itself dropped.
        set_no = 0;
        while (items_sent < ITEM_TARGET) begin
            if (set_no == 0 || $urandom_range(0, 2) == 0) begin
                drain_results();
                cfg_word = $urandom;
                if (set_no == 0)
                    cfg_word[0] = 1'b0;
                write_sort_key(cfg_word);
            end
            if (set_no == 1)
                set_size = MAX_RECORDS;
            else if (set_no == 3)
                set_size = MAX_RECORDS + 2;
            else
                set_size = $urandom_range(1, 8);
            dup_keys = ($urandom_range(0, 2) == 0);
            for (k = 0; k < set_size; k++) begin
                if (items_sent >= ITEM_TARGET - 40)
                    quiet = 1'b1;
                it      = random_record(dup_keys);
                it.last = (k == set_size - 1);
                send_record(it);
                sender_pause();
            end
            set_no++;
        end

        drain_results();
        if (err_count == 0) begin
            $display("[record_exchange_sorter_unit] OK");
        end else begin
            $display("[record_exchange_sorter_unit] ERROR");
        end
        $finish;
    end

endmodule
